[hdl/nearest_centroid_classifier_unit_macros.svh]
// Assertion macros for the nearest centroid classifier checker.
// Expects clk and rst_n in the scope of each use.
`ifndef NEAREST_CENTROID_CLASSIFIER_UNIT_MACROS_SVH
`define NEAREST_CENTROID_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define NCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ncc_pkg.sv]
// Shared widths, codes and types of the nearest centroid classifier.
// No dependencies.
`default_nettype none
package ncc_pkg;

  localparam int VAL_W      = 16;
  localparam int SQ_W       = 32;
  localparam int DIST_W     = 35;
  localparam int OUT_IDX_W  = 4;
  localparam int ROW_IN_W   = 4;
  localparam int CLUS_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_BIT = 2;
  localparam int IN_FIELDS  = 8;

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic REG_ACTIVE_CLUSTERS = 1'b0;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ncc_tag_t;

endpackage
`default_nettype wire

[hdl/ncc_store.sv]
// Centroid row memory: one write port, one registered read port.
// No package dependency.
`default_nettype none
module ncc_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 128,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/ncc_lane.sv]
// One dimension lane: difference and registered square.
// Depends on ncc_pkg.
`default_nettype none
module ncc_lane (
  input  wire logic                      clk,
  input  wire ncc_pkg::val_t             sample,
  input  wire ncc_pkg::val_t             centroid,
  output logic [ncc_pkg::SQ_W-1:0]       sq
);
  import ncc_pkg::*;

  logic signed [VAL_W:0]     diff;
  logic signed [2*VAL_W+1:0] prod;
  logic [SQ_W-1:0]           sq_r;

  assign diff = {sample[VAL_W-1], sample} - {centroid[VAL_W-1], centroid};
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    sq_r <= prod[SQ_W-1:0];
  end

  assign sq = sq_r;

endmodule
`default_nettype wire

[hdl/ncc_merge.sv]
// Merge stage: sums the lane squares, then keeps the running minimum.
// Depends on ncc_pkg.
`default_nettype none
module ncc_merge #(
  parameter int DIMS  = 8,
  parameter int ROW_W = 4,
  parameter int SUM_W = 35
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ncc_pkg::ncc_tag_t       tag_in,
  input  wire logic [ROW_W-1:0]        row_in,
  input  wire logic [ncc_pkg::SQ_W-1:0] sq_in [DIMS],
  output logic                         done,
  output logic [ROW_W-1:0]             best_row,
  output logic [SUM_W-1:0]             best_dist
);
  import ncc_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_r;
  logic [ROW_W-1:0] row_r;
  ncc_tag_t         tag_r;
  ncc_tag_t         tag_nxt;
  logic [SUM_W-1:0] best_dist_r;
  logic [ROW_W-1:0] best_row_r;
  logic             take;

  always_comb begin
    sum = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum = sum + SUM_W'(sq_in[d]);
    end
  end

  assign tag_nxt = tag_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum;
    row_r <= row_in;
  end

  // strict less-than: lowest row wins a tie
  assign take = tag_r.valid && (tag_r.first || (sum_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist_r <= sum_r;
      best_row_r  <= row_r;
    end
  end

  assign done      = tag_r.valid && tag_r.last;
  assign best_row  = best_row_r;
  assign best_dist = best_dist_r;

endmodule
`default_nettype wire

[hdl/nearest_centroid_classifier_unit.sv]
// Nearest centroid classifier: centroid memory, DIMS parallel lanes, merge.
// Write beat: the row is written to the centroid memory if in range. Classify beat: the rows are searched
// one row per cycle through the single read port of the centroid memory.
// Throughput: one write beat per cycle while idle; a classify beat holds off all input until its
// result is loaded, which waits while the output register still holds an unaccepted result.
// Reset (rst_n, synchronous) clears control, sets active_clusters to 1, keeps the memory.
`default_nettype none
module nearest_centroid_classifier_unit #(
  parameter int DIMS         = 8,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_cmd,
  input  wire logic [ncc_pkg::ROW_IN_W-1:0]      in_row_index,
  input  wire ncc_pkg::val_t                     in_value_0,
  input  wire ncc_pkg::val_t                     in_value_1,
  input  wire ncc_pkg::val_t                     in_value_2,
  input  wire ncc_pkg::val_t                     in_value_3,
  input  wire ncc_pkg::val_t                     in_value_4,
  input  wire ncc_pkg::val_t                     in_value_5,
  input  wire ncc_pkg::val_t                     in_value_6,
  input  wire ncc_pkg::val_t                     in_value_7,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [ncc_pkg::OUT_IDX_W-1:0]          out_nearest_cluster,
  output logic [ncc_pkg::DIST_W-1:0]             out_best_distance,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ncc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [ncc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ncc_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import ncc_pkg::*;

  localparam int ROW_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int WORD_W = DIMS * VAL_W;
  localparam int SUM_W  = SQ_W + $clog2(DIMS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ROW_W-1:0]  cnt_r, cnt_nxt;
  logic [CLUS_W-1:0] active_r;
  logic [ROW_W-1:0]  last_row;
  ncc_tag_t          tag_rd_r, tag_rd_nxt;
  ncc_tag_t          tag_sq_r;
  logic [ROW_W-1:0]  row_rd_r, row_sq_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  val_t              in_vals [IN_FIELDS];
  val_t              sample_r [DIMS];
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] rd_word;
  logic [SQ_W-1:0]   sq [DIMS];

  logic              in_acc;
  logic              row_ok;
  logic              mem_we;
  logic              cfg_we;
  logic              out_load;
  logic              done;
  logic [ROW_W-1:0]  best_row;
  logic [SUM_W-1:0]  best_dist;

  assign in_vals[0] = in_value_0;
  assign in_vals[1] = in_value_1;
  assign in_vals[2] = in_value_2;
  assign in_vals[3] = in_value_3;
  assign in_vals[4] = in_value_4;
  assign in_vals[5] = in_value_5;
  assign in_vals[6] = in_value_6;
  assign in_vals[7] = in_value_7;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign row_ok   = 32'(in_row_index) < MAX_CLUSTERS;
  assign mem_we   = in_acc && (in_cmd == CMD_WRITE) && row_ok;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[CFG_IDX_BIT] == REG_ACTIVE_CLUSTERS);

  always_comb begin
    prdata = '0;
    if (paddr[CFG_IDX_BIT] == REG_ACTIVE_CLUSTERS) begin
      prdata = CFG_DATA_W'(active_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CLUS_W'(1);
    end else if (cfg_we) begin
      active_r <= pwdata[CLUS_W-1:0];
    end
  end

  // zero means one row, saturate at the table depth
  always_comb begin
    if (active_r == '0) begin
      last_row = '0;
    end else if (32'(active_r) > MAX_CLUSTERS) begin
      last_row = ROW_W'(MAX_CLUSTERS - 1);
    end else begin
      last_row = ROW_W'(active_r - CLUS_W'(1));
    end
  end

  for (genvar d = 0; d < DIMS; d++) begin : g_word
    assign wr_word[d*VAL_W +: VAL_W] = in_vals[d];
  end

  ncc_store #(
    .DEPTH (MAX_CLUSTERS),
    .WIDTH (WORD_W),
    .AW    (ROW_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ROW_W'(in_row_index)),
    .wdata (wr_word),
    .raddr (cnt_r),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_CLASSIFY)) begin
      for (int d = 0; d < DIMS; d++) begin
        sample_r[d] <= in_vals[d];
      end
    end
  end

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    ncc_lane u_lane (
      .clk      (clk),
      .sample   (sample_r[d]),
      .centroid (rd_word[d*VAL_W +: VAL_W]),
      .sq       (sq[d])
    );
  end

  ncc_merge #(
    .DIMS  (DIMS),
    .ROW_W (ROW_W),
    .SUM_W (SUM_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag_sq_r),
    .row_in    (row_sq_r),
    .sq_in     (sq),
    .done      (done),
    .best_row  (best_row),
    .best_dist (best_dist)
  );

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tag_rd_nxt    = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_CLASSIFY)) begin
          cnt_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        tag_rd_nxt.valid = 1'b1;
        tag_rd_nxt.first = (cnt_r == '0);
        tag_rd_nxt.last  = (cnt_r == last_row);
        if (cnt_r == last_row) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + ROW_W'(1);
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tag_rd_r    <= '0;
      tag_sq_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tag_rd_r    <= tag_rd_nxt;
      tag_sq_r    <= tag_rd_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_rd_r <= cnt_r;
    row_sq_r <= row_rd_r;
    if (out_load) begin
      out_idx_r  <= OUT_IDX_W'(best_row);
      out_dist_r <= DIST_W'(best_dist);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_cluster = out_idx_r;
  assign out_best_distance   = out_dist_r;

endmodule
`default_nettype wire

[hdl/ncc_checker.sv]
// Port-level checker for the nearest centroid classifier, bound to the top.
// Depends on nearest_centroid_classifier_unit_macros.svh.
`default_nettype none
`include "nearest_centroid_classifier_unit_macros.svh"
module ncc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_nearest_cluster,
  input wire logic [34:0] out_best_distance
);

  `NCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_nearest_cluster) && $stable(out_best_distance),
    "result beat changed while stalled")

  `NCC_ASSERT_NXT(a_classify_busy, in_valid && in_ready && in_cmd,
    !in_ready, "input taken during classify")

  `NCC_ASSERT_NXT(a_write_one_cycle, in_valid && in_ready && !in_cmd,
    in_ready, "write beat did not finish in one cycle")

  `NCC_ASSERT_IMP(a_dist_range, out_valid,
    out_best_distance <= 35'd34358689800, "distance out of range")

endmodule

bind nearest_centroid_classifier_unit ncc_checker u_ncc_checker (.*);
`default_nettype wire
